// File: hw/rtl/xcr_pkg.sv
// Package of shared constants and types for the XMODEM checksum receiver.
`default_nettype none

package xcr_pkg;

    localparam int PAYLOAD_BYTES = 128;
    // Frame positions run from 1 up to PAYLOAD_BYTES + 3, which is the checksum byte.
    localparam int POS_W = $clog2(PAYLOAD_BYTES + 4);

    localparam logic [7:0] SOH_BYTE = 8'h01;
    localparam logic [7:0] EOT_BYTE = 8'h04;
    localparam logic [7:0] FIRST_PACKET = 8'h01;

    localparam logic [POS_W-1:0] POS_SEQ   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_CPL   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_CHECK = POS_W'(PAYLOAD_BYTES + 3);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       payload_valid;
        logic       send_ack;
        logic       send_nak;
        logic       packet_accepted;
        logic [7:0] packet_number;
        logic       end_of_transfer;
    } xcr_result_t;

endpackage

`default_nettype wire

// File: hw/rtl/xcr_if.sv
// Channel interfaces of the XMODEM checksum receiver: received bytes, results, configuration.
`default_nettype none

interface xcr_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_first;

    modport source (output valid, rx_byte, frame_first, input ready);
    modport sink (input valid, rx_byte, frame_first, output ready);
endinterface

interface xcr_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       payload_valid;
    logic       send_ack;
    logic       send_nak;
    logic       packet_accepted;
    logic [7:0] packet_number;
    logic       end_of_transfer;

    modport source (output valid, data_byte, payload_valid, send_ack, send_nak,
                    packet_accepted, packet_number, end_of_transfer, input ready);
    modport sink (input valid, data_byte, payload_valid, send_ack, send_nak,
                  packet_accepted, packet_number, end_of_transfer, output ready);
endinterface

interface xcr_cfg_if;
    logic valid;
    logic ready;
    logic data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/xcr_proto.sv
// Protocol state of the receiver and the result logic for one received byte.
`default_nettype none

module xcr_proto
    import xcr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        accept,
    input  wire logic        enable,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        frame_first,
    output xcr_result_t      result
);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic             is_data_reg, is_data_next;
    logic [7:0]       seq_reg, seq_next;
    logic             cpl_ok_reg, cpl_ok_next;
    logic [7:0]       sum_reg, sum_next;
    logic             started_reg, started_next;
    logic [7:0]       last_reg, last_next;

    always_comb
    begin
        logic sum_ok;
        sum_ok       = (sum_reg == rx_byte);
        result       = '0;
        pos_next     = pos_reg;
        is_data_next = is_data_reg;
        seq_next     = seq_reg;
        cpl_ok_next  = cpl_ok_reg;
        sum_next     = sum_reg;
        started_next = started_reg;
        last_next    = last_reg;

        if (!enable)
        begin
            // An open frame is abandoned; the transfer state is kept.
            is_data_next = 1'b0;
        end
        else if (frame_first)
        begin
            pos_next     = POS_SEQ;
            is_data_next = (rx_byte == SOH_BYTE);
            sum_next     = '0;
            cpl_ok_next  = 1'b0;
            seq_next     = '0;
            if (rx_byte == EOT_BYTE)
            begin
                result.send_ack        = 1'b1;
                result.end_of_transfer = 1'b1;
                started_next           = 1'b0;
                last_next              = '0;
            end
        end
        else if (is_data_reg)
        begin
            pos_next = pos_reg + POS_W'(1);
            if (pos_reg == POS_SEQ)
            begin
                seq_next = rx_byte;
            end
            else if (pos_reg == POS_CPL)
            begin
                cpl_ok_next = (seq_reg == ~rx_byte);
            end
            else if (pos_reg < POS_CHECK)
            begin
                sum_next = sum_reg + rx_byte;
                if (cpl_ok_reg)
                begin
                    result.data_byte     = rx_byte;
                    result.payload_valid = 1'b1;
                end
            end
            else
            begin
                // Checksum byte: judge the packet and close the frame.
                is_data_next = 1'b0;
                if (cpl_ok_reg)
                begin
                    if (!started_reg)
                    begin
                        if (seq_reg == FIRST_PACKET && sum_ok)
                        begin
                            started_next           = 1'b1;
                            last_next              = seq_reg;
                            result.send_ack        = 1'b1;
                            result.packet_accepted = 1'b1;
                            result.packet_number   = seq_reg;
                        end
                    end
                    else if (seq_reg == last_reg + 8'd1)
                    begin
                        if (sum_ok)
                        begin
                            last_next              = seq_reg;
                            result.send_ack        = 1'b1;
                            result.packet_accepted = 1'b1;
                            result.packet_number   = seq_reg;
                        end
                        else
                        begin
                            result.send_nak = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            is_data_reg <= 1'b0;
            seq_reg     <= '0;
            cpl_ok_reg  <= 1'b0;
            sum_reg     <= '0;
            started_reg <= 1'b0;
            last_reg    <= '0;
        end
        else if (accept)
        begin
            pos_reg     <= pos_next;
            is_data_reg <= is_data_next;
            seq_reg     <= seq_next;
            cpl_ok_reg  <= cpl_ok_next;
            sum_reg     <= sum_next;
            started_reg <= started_next;
            last_reg    <= last_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/xcr_out_buf.sv
// Result register with a skid stage, so an item is taken while a result waits.
`default_nettype none

module xcr_out_buf
    import xcr_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire xcr_result_t push_data,
    output logic             push_ready,
    output logic             out_valid,
    input  wire logic        out_ready,
    output xcr_result_t      out_data
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    xcr_result_t out_reg;
    xcr_result_t skid_reg;
    logic        pop;

    assign pop        = out_valid_reg && out_ready;
    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= push;
            end
            else
            begin
                out_valid_reg <= push;
            end
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
                if (push)
                begin
                    skid_reg <= push_data;
                end
            end
            else if (push)
            begin
                out_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/xmodem_checksum_receiver.sv
// Top level of the XMODEM receiver with an 8-bit additive checksum.
// The result of a byte is registered in the result buffer before it is offered.
// Throughput: one byte per cycle while the result buffer has room; the protocol update is a single add and compares.
// A two-entry result buffer takes one more byte while the result side stalls.
// Reset clears the protocol state, the result buffer and the enable register.
`default_nettype none

module xmodem_checksum_receiver
    import xcr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    xcr_rx_if.sink     rx,
    xcr_res_if.source  res,
    xcr_cfg_if.sink    cfg
);

    logic        enable_reg;
    logic        accept;
    logic        buf_ready;
    xcr_result_t result;
    xcr_result_t res_data;

    assign cfg.ready = 1'b1;
    assign rx.ready  = buf_ready;
    assign accept    = rx.valid && buf_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            enable_reg <= cfg.data;
        end
    end

    xcr_proto u_proto (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .enable      (enable_reg),
        .rx_byte     (rx.rx_byte),
        .frame_first (rx.frame_first),
        .result      (result)
    );

    xcr_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_data  (result),
        .push_ready (buf_ready),
        .out_valid  (res.valid),
        .out_ready  (res.ready),
        .out_data   (res_data)
    );

    assign res.data_byte       = res_data.data_byte;
    assign res.payload_valid   = res_data.payload_valid;
    assign res.send_ack        = res_data.send_ack;
    assign res.send_nak        = res_data.send_nak;
    assign res.packet_accepted = res_data.packet_accepted;
    assign res.packet_number   = res_data.packet_number;
    assign res.end_of_transfer = res_data.end_of_transfer;

endmodule

`default_nettype wire

// File: tb/xcr_result_checker.sv
// Checker for the XMODEM checksum receiver: predicts the result of each byte and compares it.
`timescale 1ns / 100ps

module xcr_result_checker
    import xcr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    xcr_rx_if    rx_mon,
    xcr_res_if   res_mon,
    xcr_cfg_if   cfg_mon,
    output int   mismatches,
    output int   pending_results
);

    localparam int REPORT_LIMIT = 10;

    logic             rx_enable;
    logic [POS_W-1:0] frame_pos;
    logic             in_data_frame;
    logic [7:0]       seq_byte;
    logic             seq_cpl_good;
    logic [7:0]       payload_sum;
    logic             transfer_open;
    logic [7:0]       last_accepted;

    xcr_result_t expected_results[$];

    function automatic string result_text(input xcr_result_t r);
        return $sformatf("data=%02h pv=%0b ack=%0b nak=%0b acc=%0b num=%02h eot=%0b",
                         r.data_byte, r.payload_valid, r.send_ack, r.send_nak,
                         r.packet_accepted, r.packet_number, r.end_of_transfer);
    endfunction

    // Advances the protocol state by one received byte and returns its result.
    function automatic xcr_result_t decode_rx_byte(input logic [7:0] b, input logic first);
        xcr_result_t r;
        logic        sum_good;
        r = '0;
        if (!rx_enable)
        begin
            in_data_frame = 1'b0;
            return r;
        end
        if (first)
        begin
            frame_pos     = POS_SEQ;
            in_data_frame = (b == SOH_BYTE);
            payload_sum   = 8'h00;
            seq_cpl_good  = 1'b0;
            seq_byte      = 8'h00;
            if (b == EOT_BYTE)
            begin
                r.send_ack      = 1'b1;
                r.end_of_transfer = 1'b1;
                transfer_open   = 1'b0;
                last_accepted   = 8'h00;
            end
            return r;
        end
        if (!in_data_frame)
            return r;
        if (frame_pos == POS_SEQ)
            seq_byte = b;
        else if (frame_pos == POS_CPL)
            seq_cpl_good = (seq_byte == ~b);
        else if (frame_pos < POS_CHECK)
        begin
            payload_sum = payload_sum + b;
            if (seq_cpl_good)
            begin
                r.data_byte     = b;
                r.payload_valid = 1'b1;
            end
        end
        else
        begin
            // Checksum byte: the packet is judged and the frame closed.
            sum_good = (payload_sum == b);
            if (seq_cpl_good)
            begin
                if (!transfer_open)
                begin
                    if (seq_byte == FIRST_PACKET && sum_good)
                    begin
                        transfer_open     = 1'b1;
                        last_accepted     = seq_byte;
                        r.send_ack        = 1'b1;
                        r.packet_accepted = 1'b1;
                        r.packet_number   = seq_byte;
                    end
                end
                else if (seq_byte == last_accepted + 8'd1)
                begin
                    if (sum_good)
                    begin
                        last_accepted     = seq_byte;
                        r.send_ack        = 1'b1;
                        r.packet_accepted = 1'b1;
                        r.packet_number   = seq_byte;
                    end
                    else
                        r.send_nak = 1'b1;
                end
            end
            in_data_frame = 1'b0;
        end
        frame_pos = frame_pos + 1'b1;
        return r;
    endfunction

    always @(posedge clk)
    begin : watch
        xcr_result_t got;
        xcr_result_t want;
        if (!rst_n)
        begin
            rx_enable     = 1'b0;
            frame_pos     = '0;
            in_data_frame = 1'b0;
            seq_byte      = 8'h00;
            seq_cpl_good  = 1'b0;
            payload_sum   = 8'h00;
            transfer_open = 1'b0;
            last_accepted = 8'h00;
            expected_results.delete();
            mismatches      = 0;
            pending_results = 0;
        end
        else
        begin
            if (res_mon.valid && res_mon.ready)
            begin
                got.data_byte       = res_mon.data_byte;
                got.payload_valid   = res_mon.payload_valid;
                got.send_ack        = res_mon.send_ack;
                got.send_nak        = res_mon.send_nak;
                got.packet_accepted = res_mon.packet_accepted;
                got.packet_number   = res_mon.packet_number;
                got.end_of_transfer = res_mon.end_of_transfer;
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with no byte pending: %s", $time,
                                 result_text(got));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.data_byte !== want.data_byte
                        || got.payload_valid !== want.payload_valid
                        || got.send_ack !== want.send_ack
                        || got.send_nak !== want.send_nak
                        || got.packet_accepted !== want.packet_accepted
                        || got.packet_number !== want.packet_number
                        || got.end_of_transfer !== want.end_of_transfer)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: mismatch, expected %s, got %s", $time,
                                     result_text(want), result_text(got));
                    end
                end
            end
            if (cfg_mon.valid && cfg_mon.ready)
                rx_enable = cfg_mon.data;
            if (rx_mon.valid && rx_mon.ready)
                expected_results.push_back(decode_rx_byte(rx_mon.rx_byte, rx_mon.frame_first));
            pending_results = expected_results.size();
        end
    end

endmodule

// File: tb/xmodem_checksum_receiver_tb.sv
// Testbench top for the XMODEM checksum receiver: clock, reset, frame stimulus and verdict.
`timescale 1ns / 100ps

module xmodem_checksum_receiver_tb;
    import xcr_pkg::*;

    localparam int HOLD_OFF_CYCLES = 80;
    localparam int RANDOM_ITEMS    = 1300;
    localparam int DRAIN_CYCLES    = 8;

    typedef enum int {
        FR_GOOD,
        FR_BAD_SUM,
        FR_BAD_CPL,
        FR_WRONG_NUM,
        FR_SHORT,
        FR_EOT,
        FR_OTHER
    } frame_kind_t;

    logic       clk = 1'b0;
    logic       rst_n;
    int         mismatch_count;
    int         pending_count;
    // Stimulus-side view of the protocol, used to build well-formed frames and to count enabled bytes.
    logic       rx_enabled = 1'b0;
    logic [7:0] next_seq = FIRST_PACKET;
    bit         steady_send = 1'b0;
    bit         hold_off_req = 1'b0;
    int         enabled_items = 0;

    xcr_rx_if  rx_ch ();
    xcr_res_if res_ch ();
    xcr_cfg_if cfg_ch ();

    xmodem_checksum_receiver dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    xcr_result_checker chk (
        .clk             (clk),
        .rst_n           (rst_n),
        .rx_mon          (rx_ch),
        .res_mon         (res_ch),
        .cfg_mon         (cfg_ch),
        .mismatches      (mismatch_count),
        .pending_results (pending_count)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #3_000_000;
        $display("xmodem_checksum_receiver test failed");
        $finish;
    end

    // Mostly no gap or a short one, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 94)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [7:0] rand_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'h00;
        if (r < 16)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic frame_kind_t pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return FR_GOOD;
        if (r < 50)
            return FR_BAD_SUM;
        if (r < 58)
            return FR_BAD_CPL;
        if (r < 66)
            return FR_WRONG_NUM;
        if (r < 86)
            return FR_SHORT;
        if (r < 92)
            return FR_EOT;
        return FR_OTHER;
    endfunction

    task automatic put_byte(input logic [7:0] b, input logic first);
        int gap;
        gap = steady_send ? 0 : idle_len();
        if (gap > 0)
        begin
            rx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        rx_ch.valid       <= 1'b1;
        rx_ch.rx_byte     <= b;
        rx_ch.frame_first <= first;
        @(posedge clk);
        while (!rx_ch.ready)
            @(posedge clk);
        if (rx_enabled)
            enabled_items++;
    endtask

    // The enable is only written once every byte sent so far has its result.
    task automatic write_enable(input logic en);
        rx_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= en;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
        rx_enabled = en;
    endtask

    task automatic send_frame(input frame_kind_t kind);
        logic [7:0] frm[PAYLOAD_BYTES + 3];
        logic [7:0] seq;
        logic [7:0] sum;
        logic [7:0] b;
        int         len;
        int         k;
        steady_send = ($urandom_range(0, 3) == 0);
        case (kind)
            FR_EOT:
            begin
                put_byte(EOT_BYTE, 1'b1);
                if (rx_enabled)
                    next_seq = FIRST_PACKET;
            end
            FR_OTHER:
            begin
                do
                    b = 8'($urandom_range(0, 255));
                while (b == SOH_BYTE || b == EOT_BYTE);
                put_byte(b, 1'b1);
                repeat ($urandom_range(0, 4)) put_byte(rand_byte(), 1'b0);
            end
            default:
            begin
                seq = next_seq;
                if (kind == FR_WRONG_NUM)
                    seq = ($urandom_range(0, 1) == 0) ? next_seq - 8'd1
                                                      : next_seq + 8'($urandom_range(1, 255));
                frm[0] = seq;
                frm[1] = ~seq;
                if (kind == FR_BAD_CPL)
                    frm[1] = ~seq ^ 8'($urandom_range(1, 255));
                sum = 8'h00;
                for (k = 2; k < PAYLOAD_BYTES + 2; k++)
                begin
                    frm[k] = rand_byte();
                    sum    = sum + frm[k];
                end
                frm[PAYLOAD_BYTES + 2] = (kind == FR_BAD_SUM) ? sum + 8'($urandom_range(1, 255))
                                                              : sum;
                len = PAYLOAD_BYTES + 3;
                // A short frame stops before its checksum, often right at the end.
                if (kind == FR_SHORT)
                    len = ($urandom_range(0, 2) != 0)
                          ? $urandom_range(0, 8)
                          : $urandom_range(PAYLOAD_BYTES - 2, PAYLOAD_BYTES + 2);
                put_byte(SOH_BYTE, 1'b1);
                for (k = 0; k < len; k++)
                    put_byte(frm[k], 1'b0);
                if (kind == FR_GOOD && rx_enabled)
                    next_seq = seq + 8'd1;
                if (kind != FR_SHORT && $urandom_range(0, 4) == 0)
                    repeat ($urandom_range(1, 3)) put_byte(rand_byte(), 1'b0);
            end
        endcase
    endtask

    initial
    begin : result_ready_drive
        int r;
        bit hold_off_done;
        hold_off_done = 1'b0;
        res_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req && !hold_off_done)
            begin
                // Long hold-off so that the result buffer fills and input stalls.
                hold_off_done = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                begin
                    res_ch.ready <= 1'b1;
                    repeat ($urandom_range(20, 120)) @(posedge clk);
                end
                else if (r < 70)
                begin
                    res_ch.ready <= 1'b1;
                    @(posedge clk);
                end
                else
                begin
                    res_ch.ready <= 1'b0;
                    repeat (idle_len() + 1) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        rst_n             <= 1'b0;
        rx_ch.valid       <= 1'b0;
        rx_ch.rx_byte     <= 8'h00;
        rx_ch.frame_first <= 1'b0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.data       <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The receiver comes out of reset disabled: these bytes give empty results.
        put_byte(SOH_BYTE, 1'b1);
        put_byte(8'hFF, 1'b0);
        write_enable(1'b1);
        put_byte(8'h00, 1'b0);
        put_byte(EOT_BYTE, 1'b1);
        put_byte(8'hFF, 1'b1);
        put_byte(8'h80, 1'b0);
        // Short frame, cut off by the next first byte.
        put_byte(SOH_BYTE, 1'b1);
        put_byte(FIRST_PACKET, 1'b0);
        put_byte(~FIRST_PACKET, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'hFF, 1'b0);
        put_byte(8'h7F, 1'b0);
        put_byte(SOH_BYTE, 1'b1);
        put_byte(EOT_BYTE, 1'b1);
        // Bad complement: the payload must not be passed on.
        put_byte(SOH_BYTE, 1'b1);
        put_byte(FIRST_PACKET, 1'b0);
        put_byte(8'h00, 1'b0);
        put_byte(8'h55, 1'b0);
        put_byte(8'hAA, 1'b0);

        hold_off_req = 1'b1;
        while (enabled_items < RANDOM_ITEMS / 2)
            send_frame(pick_kind());

        // Disable with a frame open, then check that the transfer state survives.
        send_frame(FR_SHORT);
        write_enable(1'b0);
        repeat (5)
        begin
            case ($urandom_range(0, 2))
                0: send_frame(FR_EOT);
                1: send_frame(FR_OTHER);
                default: send_frame(FR_SHORT);
            endcase
        end
        write_enable(1'b1);
        repeat (3) put_byte(rand_byte(), 1'b0);
        while (enabled_items < RANDOM_ITEMS)
            send_frame(pick_kind());

        rx_ch.valid <= 1'b0;
        @(negedge clk);
        while (pending_count != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_count == 0)
            $display("xmodem_checksum_receiver test passed");
        else
            $display("xmodem_checksum_receiver test failed");
        $finish;
    end

endmodule
